### rtl/first_fit_slot_allocator_defines.svh
// Assertion macros shared by the checker of the first-fit slot allocator.
`ifndef FIRST_FIT_SLOT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define FFSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("first fit slot allocator: same-cycle check failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define FFSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("first fit slot allocator: next-cycle check failed");

`endif

### rtl/ffsa_pkg.sv
// Shared types and constants of the first-fit slot allocator.
`timescale 1ns / 1ps
package ffsa_pkg;

    localparam int SLOT_BITS         = 10;
    localparam int AMOUNT_BITS       = 32;
    localparam int NUM_SLOTS_DEFAULT = 1024;
    localparam int CAP_BITS_DEFAULT  = 32;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    typedef struct packed {
        logic                   cmd;
        logic [SLOT_BITS-1:0]   slot_index;
        logic [AMOUNT_BITS-1:0] amount;
    } in_item_t;

    typedef struct packed {
        logic                 granted;
        logic [SLOT_BITS-1:0] slot;
    } out_item_t;

endpackage

### rtl/first_fit_slot_allocator.sv
// Top level of the first-fit slot allocator: front end, work queue, tree engine, result queue.
//
//   channel   | handshake         | payload
//   ----------+-------------------+-------------------------------------
//   request   | push / full       | in_item_t  (cmd, slot_index, amount)
//   response  | pop / empty       | out_item_t (granted, slot)
//
// An allocate walks the tree down to a leaf and back up, a tree level a cycle, reading the tree
// memory on the way down and writing the new maxima on the way up. A load writes its leaf and
// walks up the same way, an oversized allocate is refused without a walk; a load past the row
// never leaves the front. After reset a clearing pass zeroes the tree, with full held high.
// A two-entry queue on each side lets requests queue up while the engine works and while the
// oldest response waits for pop.
`timescale 1ns / 1ps
module first_fit_slot_allocator
    import ffsa_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT,
    parameter int CAP_BITS  = CAP_BITS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  request,
    input  logic      pop,
    output logic      empty,
    output out_item_t response
);

    localparam int WORK_BITS = 2 + SLOT_BITS + CAP_BITS;
    localparam int RES_BITS  = $bits(out_item_t);

    logic                 clearing;
    logic                 cmd_push, cmd_full, cmd_pop, cmd_empty;
    logic [WORK_BITS-1:0] cmd_wdata, cmd_rdata;
    logic                 res_push, res_full;
    out_item_t            res_data;
    logic [RES_BITS-1:0]  res_rdata;

    ffsa_front #(
        .NUM_SLOTS (NUM_SLOTS),
        .CAP_BITS  (CAP_BITS),
        .WORK_BITS (WORK_BITS)
    ) u_front (
        .request  (request),
        .push     (push),
        .full     (full),
        .q_full   (cmd_full),
        .clearing (clearing),
        .q_push   (cmd_push),
        .q_data   (cmd_wdata)
    );

    ffsa_fifo #(
        .WIDTH (WORK_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    ffsa_engine #(
        .NUM_SLOTS (NUM_SLOTS),
        .CAP_BITS  (CAP_BITS),
        .WORK_BITS (WORK_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_rdata),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data),
        .clearing  (clearing)
    );

    ffsa_fifo #(
        .WIDTH (RES_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign response = out_item_t'(res_rdata);

endmodule

### rtl/ffsa_fifo.sv
// Small first-in first-out queue with registered storage.
`timescale 1ns / 1ps
module ffsa_fifo
    import ffsa_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/ffsa_front.sv
// Front end: accepts request transactions, drops stray loads and tags oversized requests.
`timescale 1ns / 1ps
module ffsa_front
    import ffsa_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT,
    parameter int CAP_BITS  = CAP_BITS_DEFAULT,
    parameter int WORK_BITS = 2 + SLOT_BITS + CAP_BITS
) (
    input  in_item_t               request,
    input  logic                   push,
    output logic                   full,
    input  logic                   q_full,
    input  logic                   clearing,
    output logic                   q_push,
    output logic [WORK_BITS-1:0]   q_data
);

    logic        accept;
    logic        in_range;
    logic        oversize;
    logic [63:0] amt_wide;

    assign full     = q_full || clearing;
    assign accept   = push && !full;
    assign in_range = 32'(request.slot_index) < NUM_SLOTS;
    assign amt_wide = 64'(request.amount);

    // An allocate asking for more than any slot can hold can never be granted.
    assign oversize = (amt_wide >> CAP_BITS) != 64'd0;

    // A load past the end of the row is taken and then forgotten.
    assign q_push = accept && ((request.cmd == CMD_ALLOC) || in_range);
    assign q_data = {request.cmd, oversize, request.slot_index, amt_wide[CAP_BITS-1:0]};

endmodule

### rtl/ffsa_engine.sv
// Back end: max tree in memory, walked down to find a slot and up to refresh the maxima.
`timescale 1ns / 1ps
module ffsa_engine
    import ffsa_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT,
    parameter int CAP_BITS  = CAP_BITS_DEFAULT,
    parameter int WORK_BITS = 2 + SLOT_BITS + CAP_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_empty,
    input  logic [WORK_BITS-1:0] cmd_data,
    output logic                 cmd_pop,
    input  logic                 res_full,
    output logic                 res_push,
    output out_item_t            res_data,
    output logic                 clearing
);

    localparam int LEVELS     = $clog2(NUM_SLOTS);
    localparam int NODE_BITS  = LEVELS + 1;
    localparam int TREE_DEPTH = 2 ** NODE_BITS;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ROOT  = 3'd2;
    localparam logic [2:0] S_DOWN  = 3'd3;
    localparam logic [2:0] S_LEAF  = 3'd4;
    localparam logic [2:0] S_UP    = 3'd5;

    localparam logic [NODE_BITS-1:0] ROOT_NODE = NODE_BITS'(1);

    logic [CAP_BITS-1:0]  tree_reg [TREE_DEPTH];
    logic [CAP_BITS-1:0]  rdata_reg;

    logic [2:0]           state_reg, state_next;
    logic [NODE_BITS-1:0] node_reg, node_next;
    logic [NODE_BITS-1:0] clr_reg, clr_next;
    logic [CAP_BITS-1:0]  amt_reg, amt_next;
    logic [CAP_BITS-1:0]  val_reg, val_next;

    logic                 mem_we;
    logic [NODE_BITS-1:0] mem_waddr;
    logic [CAP_BITS-1:0]  mem_wdata;
    logic [NODE_BITS-1:0] mem_raddr;

    logic                 w_alloc;
    logic                 w_over;
    logic [SLOT_BITS-1:0] w_slot;
    logic [CAP_BITS-1:0]  w_cap;
    logic [NODE_BITS-1:0] leaf_node;
    logic [NODE_BITS-1:0] child;
    logic [NODE_BITS-1:0] parent;
    logic [CAP_BITS-1:0]  pmax;

    assign w_alloc   = cmd_data[WORK_BITS-1];
    assign w_over    = cmd_data[WORK_BITS-2];
    assign w_slot    = cmd_data[CAP_BITS +: SLOT_BITS];
    assign w_cap     = cmd_data[CAP_BITS-1:0];
    assign leaf_node = {1'b1, LEVELS'(w_slot)};

    // Left child holds enough room: stay left, as first fit asks.
    assign child  = {node_reg[LEVELS-1:0], !(rdata_reg >= amt_reg)};
    assign parent = node_reg >> 1;
    assign pmax   = (rdata_reg > val_reg) ? rdata_reg : val_reg;

    assign clearing = (state_reg == S_CLEAR);

    always_comb
    begin
        state_next = state_reg;
        node_next  = node_reg;
        clr_next   = clr_reg;
        amt_next   = amt_reg;
        val_next   = val_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_raddr  = '0;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        res_data   = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop = 1'b1;
                    if (w_alloc == CMD_ALLOC)
                    begin
                        if (w_over)
                        begin
                            res_push = 1'b1;
                        end
                        else
                        begin
                            amt_next   = w_cap;
                            mem_raddr  = ROOT_NODE;
                            state_next = S_ROOT;
                        end
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = leaf_node;
                        mem_wdata  = w_cap;
                        val_next   = w_cap;
                        node_next  = leaf_node;
                        mem_raddr  = leaf_node ^ ROOT_NODE;
                        state_next = S_UP;
                    end
                end
            end
            S_ROOT:
            begin
                if (rdata_reg < amt_reg)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    node_next  = ROOT_NODE;
                    mem_raddr  = NODE_BITS'(2);
                    state_next = S_DOWN;
                end
            end
            S_DOWN:
            begin
                node_next = child;
                if (child[LEVELS])
                begin
                    mem_raddr  = child;
                    state_next = S_LEAF;
                end
                else
                begin
                    mem_raddr = {child[LEVELS-1:0], 1'b0};
                end
            end
            S_LEAF:
            begin
                mem_we           = 1'b1;
                mem_waddr        = node_reg;
                mem_wdata        = rdata_reg - amt_reg;
                val_next         = rdata_reg - amt_reg;
                res_push         = 1'b1;
                res_data.granted = 1'b1;
                res_data.slot    = SLOT_BITS'(node_reg[LEVELS-1:0]);
                mem_raddr        = node_reg ^ ROOT_NODE;
                state_next       = S_UP;
            end
            S_UP:
            begin
                // The sibling read last cycle meets the value carried up from below.
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = pmax;
                if (parent == ROOT_NODE)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    node_next = parent;
                    val_next  = pmax;
                    mem_raddr = parent ^ ROOT_NODE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        amt_reg  <= amt_next;
        val_reg  <= val_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tree_reg[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= tree_reg[mem_raddr];
    end

endmodule

### rtl/ffsa_checker.sv
// Port-level assertions for the first-fit slot allocator, bound to the top level.
`timescale 1ns / 1ps
`include "first_fit_slot_allocator_defines.svh"
module ffsa_checker
    import ffsa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      full,
    input logic      pop,
    input logic      empty,
    input out_item_t response
);

    // A refused allocate always reports slot zero.
    `FFSA_ASSERT_NOW(a_denied_slot_zero, !empty && !response.granted, response.slot == '0)

    // The tree is still being cleared right after reset, so no request is taken.
    `FFSA_ASSERT_NOW(a_full_after_reset, !$past(rst_n), full)

    // A response left waiting keeps its value.
    `FFSA_ASSERT_NEXT(a_response_holds, !empty && !pop, !empty && $stable(response))

endmodule

bind first_fit_slot_allocator ffsa_checker u_checker (.*);
